// ===== hw/rtl/pfdm_pkg.sv =====
// Shared types, codes and constants of the PWM frequency and duty meter.
`default_nettype none

package pfdm_pkg;

    localparam int unsigned CAP_W       = 32;
    localparam int unsigned ACTION_W    = 2;
    localparam int unsigned DUTY_W      = 15;
    localparam int unsigned FREQ_W      = 40;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam int unsigned COUNTER_BITS_DEFAULT  = 32;
    localparam int unsigned FRACTION_BITS_DEFAULT = 8;

    localparam logic [CAP_W-1:0] TIMER_CLOCK_RESET = 32'd1000000;
    localparam logic [CAP_W-1:0] RELOAD_RESET      = 32'hFFFF_FFFF;

    // Duty is scaled by one hundred; seven bits cover that factor.
    localparam int unsigned PERCENT_SCALE = 100;
    localparam int unsigned PERCENT_BITS  = 7;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] OVF_INACTIVE = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE   = 2'd0,
        ACT_EDGE     = 2'd1,
        ACT_OVERFLOW = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMER_CLOCK = 1'b0,
        REG_RELOAD      = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR_FREQ,
        OP_CLEAR_BOTH,
        OP_FREQ,
        OP_SAMPLE,
        OP_SAMPLE_SAT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CAP_W-1:0] operand_a;
        logic [CAP_W-1:0] operand_b;
        logic             inactive;
    } t_cmd;

    typedef struct packed {
        logic             start;
        logic             duty_mode;
        logic [CAP_W-1:0] dividend;
        logic [CAP_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ===== hw/rtl/pfdm_if.sv =====
// Handshake channel interfaces: capture input, result output and register writes.
`default_nettype none

interface pfdm_in_if;
    import pfdm_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CAP_W-1:0]    period_capture;
    logic [CAP_W-1:0]    high_capture;

    modport source (output valid, output action, output period_capture,
                    output high_capture, input ready);
    modport sink   (input valid, input action, input period_capture,
                    input high_capture, output ready);
endinterface

interface pfdm_out_if;
    import pfdm_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_percent_q8;
    logic [FREQ_W-1:0] frequency_hz_q8;
    logic              signal_inactive;

    modport source (output valid, output duty_percent_q8, output frequency_hz_q8,
                    output signal_inactive, input ready);
    modport sink   (input valid, input duty_percent_q8, input frequency_hz_q8,
                    input signal_inactive, output ready);
endinterface

interface pfdm_cfg_if;
    import pfdm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfdm_front.sv =====
// Front end: accepts capture events, tracks edge and overflow state, issues commands.
`default_nettype none

module pfdm_front #(
    parameter int unsigned COUNTER_BITS = pfdm_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    pfdm_in_if.sink                         i_in,
    input  wire logic [pfdm_pkg::CAP_W-1:0] i_reload_value,
    output logic                            o_push_valid,
    input  wire logic                       i_push_ready,
    output pfdm_pkg::t_cmd                  o_push_data
);
    import pfdm_pkg::*;

    logic                    r_first_edge_pending;
    logic                    n_first_edge_pending;
    logic [COUNTER_BITS-1:0] r_last_edge_count;
    logic [COUNTER_BITS-1:0] n_last_edge_count;
    logic [1:0]              r_overflow_run;
    logic [1:0]              n_overflow_run;

    logic                    accept;
    logic [COUNTER_BITS-1:0] cap;
    logic [COUNTER_BITS-1:0] high;
    logic [COUNTER_BITS-1:0] diff;
    logic [COUNTER_BITS-1:0] wrapped;
    logic [COUNTER_BITS-1:0] delta;

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign accept       = i_in.valid && i_push_ready;

    assign cap  = i_in.period_capture[COUNTER_BITS-1:0];
    assign high = i_in.high_capture[COUNTER_BITS-1:0];

    // A capture below the previous one means the counter wrapped at the reload value.
    assign diff    = cap - r_last_edge_count;
    assign wrapped = diff + i_reload_value[COUNTER_BITS-1:0] + COUNTER_BITS'(1);
    assign delta   = (cap > r_last_edge_count) ? diff :
                     (cap < r_last_edge_count) ? wrapped : '0;

    always_comb begin
        n_first_edge_pending  = r_first_edge_pending;
        n_last_edge_count     = r_last_edge_count;
        n_overflow_run        = r_overflow_run;
        o_push_data.op        = OP_HOLD;
        o_push_data.operand_a = CAP_W'(cap);
        o_push_data.operand_b = CAP_W'(high);
        case (t_action'(i_in.action))
            ACT_SAMPLE: begin
                if (cap == '0) begin
                    o_push_data.op = OP_CLEAR_BOTH;
                end else if (high >= cap) begin
                    o_push_data.op = OP_SAMPLE_SAT;
                end else begin
                    o_push_data.op = OP_SAMPLE;
                end
            end
            ACT_EDGE: begin
                n_overflow_run    = '0;
                n_last_edge_count = cap;
                if (r_first_edge_pending) begin
                    n_first_edge_pending = 1'b0;
                end else if (delta == '0) begin
                    o_push_data.op = OP_CLEAR_FREQ;
                end else begin
                    o_push_data.op        = OP_FREQ;
                    o_push_data.operand_a = CAP_W'(delta);
                end
            end
            ACT_OVERFLOW: begin
                if (r_overflow_run != OVF_INACTIVE) begin
                    n_overflow_run = r_overflow_run + 2'd1;
                    if (n_overflow_run == OVF_INACTIVE) begin
                        o_push_data.op = OP_CLEAR_FREQ;
                    end
                end
            end
            default: begin
            end
        endcase
        o_push_data.inactive = (n_overflow_run == OVF_INACTIVE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_edge_pending <= 1'b1;
            r_last_edge_count    <= '0;
            r_overflow_run       <= '0;
        end else if (accept) begin
            r_first_edge_pending <= n_first_edge_pending;
            r_last_edge_count    <= n_last_edge_count;
            r_overflow_run       <= n_overflow_run;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfdm_fifo.sv =====
// Short command queue between the front end and the arithmetic back end.
`default_nettype none

module pfdm_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire pfdm_pkg::t_cmd i_push_data,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output pfdm_pkg::t_cmd      o_pop_data
);
    import pfdm_pkg::*;

    localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != COUNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - COUNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(QUEUE_DEPTH))
        else $error("command queue count exceeds its depth");

    a_pointers_meet_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("command queue pointers differ while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pfdm_div.sv =====
// Bit-serial restoring divider shared by the frequency and duty quotients.
`default_nettype none

module pfdm_div #(
    parameter int unsigned FRACTION_BITS = pfdm_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire pfdm_pkg::t_div_req                       i_req,
    output logic                                          o_done,
    output logic [pfdm_pkg::CAP_W+FRACTION_BITS-1:0]      o_quotient
);
    import pfdm_pkg::*;

    localparam int unsigned NUM_W    = CAP_W + FRACTION_BITS;
    localparam int unsigned CNT_W    = $clog2(NUM_W + 1);
    localparam int unsigned SCALED_W = CAP_W + PERCENT_BITS;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [CAP_W-1:0]    r_rem;
    logic [CAP_W-1:0]    r_div;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quo;

    logic [SCALED_W-1:0] scaled;
    logic [CAP_W:0]      trial;
    logic [CAP_W:0]      trial_sub;
    logic                fits;

    // For the duty quotient the dividend is high * 100 * 2^F. Its bits above the
    // quotient's width are already below the divisor, so they seed the remainder.
    assign scaled    = SCALED_W'(i_req.dividend) * SCALED_W'(PERCENT_SCALE);
    assign trial     = {r_rem, r_num[NUM_W-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign fits      = (trial >= {1'b0, r_div});

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.duty_mode ? CNT_W'(PERCENT_BITS + FRACTION_BITS)
                                          : CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_quo <= '0;
            if (i_req.duty_mode) begin
                r_rem <= scaled[SCALED_W-1:PERCENT_BITS];
                r_num <= NUM_W'(scaled[PERCENT_BITS-1:0]) << (NUM_W - PERCENT_BITS);
            end else begin
                r_rem <= '0;
                r_num <= NUM_W'(i_req.dividend) << FRACTION_BITS;
            end
        end else if (r_busy) begin
            r_rem <= fits ? trial_sub[CAP_W-1:0] : trial[CAP_W-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

`ifndef NO_ASSERTIONS
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_remainder_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pfdm_back.sv =====
// Back end: executes queued commands, holds duty and frequency, drives the result register.
`default_nettype none

module pfdm_back #(
    parameter int unsigned FRACTION_BITS = pfdm_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_pop_valid,
    output logic                                           o_pop_ready,
    input  wire pfdm_pkg::t_cmd                            i_pop_data,
    input  wire logic [pfdm_pkg::CAP_W-1:0]                i_timer_clock_hz,
    output pfdm_pkg::t_div_req                             o_div_req,
    input  wire logic                                      i_div_done,
    input  wire logic [pfdm_pkg::CAP_W+FRACTION_BITS-1:0]  i_div_quotient,
    pfdm_out_if.source                                     o_out
);
    import pfdm_pkg::*;

    localparam int unsigned NUM_W = CAP_W + FRACTION_BITS;
    localparam int unsigned EXT_W = NUM_W + FREQ_W;
    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(PERCENT_SCALE << FRACTION_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREQ_WAIT,
        S_DUTY_WAIT,
        S_EMIT
    } t_state;

    t_state            r_state;
    t_op               r_op;
    t_div_req          r_div_req;
    logic [CAP_W-1:0]  r_period;
    logic [CAP_W-1:0]  r_high;
    logic [DUTY_W-1:0] r_duty;
    logic [FREQ_W-1:0] r_freq;
    logic              r_inactive;
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_duty;
    logic [FREQ_W-1:0] r_out_freq;
    logic              r_out_inactive;

    logic [EXT_W-1:0]  quo_ext;
    logic [FREQ_W-1:0] freq_sat;

    assign quo_ext  = EXT_W'(i_div_quotient);
    assign freq_sat = (|quo_ext[EXT_W-1:FREQ_W]) ? '1 : quo_ext[FREQ_W-1:0];

    assign o_pop_ready           = (r_state == S_IDLE);
    assign o_div_req             = r_div_req;
    assign o_out.valid           = r_out_valid;
    assign o_out.duty_percent_q8 = r_out_duty;
    assign o_out.frequency_hz_q8 = r_out_freq;
    assign o_out.signal_inactive = r_out_inactive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_HOLD;
            r_div_req   <= '0;
            r_duty      <= '0;
            r_freq      <= '0;
            r_inactive  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The start pulse lasts one cycle; no new division is launched in that cycle.
            if (r_div_req.start) begin
                r_div_req.start <= 1'b0;
            end
            if (r_state == S_EMIT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_op       <= i_pop_data.op;
                        r_inactive <= i_pop_data.inactive;
                        r_period   <= i_pop_data.operand_a;
                        r_high     <= i_pop_data.operand_b;
                        case (i_pop_data.op)
                            OP_CLEAR_FREQ: begin
                                r_freq  <= '0;
                                r_state <= S_EMIT;
                            end
                            OP_CLEAR_BOTH: begin
                                r_freq  <= '0;
                                r_duty  <= '0;
                                r_state <= S_EMIT;
                            end
                            OP_FREQ, OP_SAMPLE, OP_SAMPLE_SAT: begin
                                r_div_req <= '{start: 1'b1, duty_mode: 1'b0,
                                               dividend: i_timer_clock_hz,
                                               divisor: i_pop_data.operand_a};
                                r_state   <= S_FREQ_WAIT;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_FREQ_WAIT: begin
                    if (i_div_done) begin
                        r_freq <= freq_sat;
                        if (r_op == OP_SAMPLE) begin
                            r_div_req <= '{start: 1'b1, duty_mode: 1'b1,
                                           dividend: r_high, divisor: r_period};
                            r_state   <= S_DUTY_WAIT;
                        end else begin
                            if (r_op == OP_SAMPLE_SAT) begin
                                r_duty <= DUTY_FULL;
                            end
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DUTY_WAIT: begin
                    if (i_div_done) begin
                        r_duty  <= i_div_quotient[DUTY_W-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_duty     <= r_duty;
                        r_out_freq     <= r_freq;
                        r_out_inactive <= r_inactive;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> (r_state == S_FREQ_WAIT || r_state == S_DUTY_WAIT))
        else $error("divider result arrived with no division pending");

    a_duty_wait_only_for_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUTY_WAIT) |-> (r_op == OP_SAMPLE))
        else $error("duty division for a command that needs none");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pwm_frequency_duty_meter_core.sv =====
// PWM frequency and duty meter: top level with register port, front end, queue and back end.
//
// Use: capture events enter on i_in. Action 0 carries a period and a high-time
// count, action 1 a counter value latched at a rising edge, action 2 a counter
// overflow; action 3 is ignored. Every accepted transaction yields exactly one
// result transaction on o_out: held duty and frequency in unsigned fixed point
// with FRACTION_BITS fraction bits, and the inactivity flag.
// Registers are written over i_cfg (index 0 timer clock, index 1 reload value),
// always ready; the user must write them only while no event is in flight, and
// the block itself does not enforce this. Events that need no division go
// straight to the result register; an edge needs one division, a period sample
// a frequency and then a duty division (no duty division when the high time
// reaches the period). The bit-serial divider finds one quotient bit a cycle;
// the back end handles one event at a time and takes the next only once the
// result of the last has moved to the output register.
// A two-entry queue lets the front end take new events while the back end
// divides or while a result waits in the output register for a stalled receiver.
// Reset is synchronous: edge and overflow state, held values and registers
// return to their reset values and no result is pending.
`default_nettype none

module pwm_frequency_duty_meter_core #(
    parameter int unsigned COUNTER_BITS  = pfdm_pkg::COUNTER_BITS_DEFAULT,
    parameter int unsigned FRACTION_BITS = pfdm_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfdm_in_if.sink    i_in,
    pfdm_cfg_if.sink   i_cfg,
    pfdm_out_if.source o_out
);
    import pfdm_pkg::*;

    logic [CAP_W-1:0] r_timer_clock_hz;
    logic [CAP_W-1:0] r_reload_value;

    logic                              push_valid;
    logic                              push_ready;
    t_cmd                              push_data;
    logic                              pop_valid;
    logic                              pop_ready;
    t_cmd                              pop_data;
    t_div_req                          div_req;
    logic                              div_done;
    logic [CAP_W+FRACTION_BITS-1:0]    div_quotient;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_clock_hz <= TIMER_CLOCK_RESET;
            r_reload_value   <= RELOAD_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_index'(i_cfg.index))
                REG_TIMER_CLOCK: r_timer_clock_hz <= i_cfg.data;
                REG_RELOAD:      r_reload_value   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    pfdm_front #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_reload_value (r_reload_value),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_data    (push_data)
    );

    pfdm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    pfdm_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    pfdm_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (pop_valid),
        .o_pop_ready      (pop_ready),
        .i_pop_data       (pop_data),
        .i_timer_clock_hz (r_timer_clock_hz),
        .o_div_req        (div_req),
        .i_div_done       (div_done),
        .i_div_quotient   (div_quotient),
        .o_out            (o_out)
    );

endmodule

`default_nettype wire
